// ===== rtl/rrfb_pkg.sv =====
// Shared constants, types and helpers of the rounded rectangle fill and blend shader.
package rrfb_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int REG_BITS   = COORD_BITS + 1;
  localparam int RAD_BITS   = COORD_BITS + 3;
  localparam int COLOR_BITS = 32;
  localparam int CFG_IW     = 3;

  localparam int FX_ONE  = 1 << FRAC_BITS;
  localparam int FX_HALF = 1 << (FRAC_BITS - 1);

  localparam int CW = COORD_BITS + 4;
  localparam int DW = CW + FRAC_BITS + 2;
  localparam int RW = RAD_BITS + FRAC_BITS - 4;
  localparam int SW = REG_BITS + FRAC_BITS - 1;
  localparam int MW = RW + 1;

  localparam int SQ_STEPS  = 3;
  localparam int ROOT_BITS = MW + 1;
  localparam int SQ_STAGES = (ROOT_BITS + SQ_STEPS - 1) / SQ_STEPS;
  localparam int NROOT     = SQ_STAGES * SQ_STEPS;
  localparam int SQ_PAD_W  = 2 * NROOT;
  localparam int REM_W     = NROOT + 4;

  localparam int IN_W = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IW-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_RADIUS = 3'd4,
    REG_COLOR  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [REG_BITS-1:0] left;
    logic [REG_BITS-1:0] top;
    logic [REG_BITS-1:0] width;
    logic [REG_BITS-1:0] height;
    logic [RW-1:0]       r;
  } geom_cfg_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] dest;
    logic                  hit;
    logic                  corner;
    logic [SQ_PAD_W-1:0]   sq;
  } geo_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] dest;
    logic                  hit;
    logic                  corner;
    logic [NROOT-1:0]      rdist;
  } root_t;

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ===== rtl/rrfb_geom.sv =====
// Box test, corner selection and squared corner distance, three stages.
module rrfb_geom (
  input  logic                              clk,
  input  logic                              rst,
  input  rrfb_pkg::geom_cfg_t               cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rrfb_pkg::COORD_BITS-1:0]   px,
  input  logic [rrfb_pkg::COORD_BITS-1:0]   py,
  input  logic [rrfb_pkg::COLOR_BITS-1:0]   dest,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rrfb_pkg::geo_t                    out_item
);

  localparam int CW = rrfb_pkg::CW;
  localparam int DW = rrfb_pkg::DW;
  localparam int MW = rrfb_pkg::MW;
  localparam int FB = rrfb_pkg::FRAC_BITS;

  logic signed [CW-1:0] x1, y1, x2, y2, pxs, pys, ri;
  logic signed [DW-1:0] rr, lx, rx, ty, by, dx, dy;
  logic nz, inbox, left, right, top, bottom, corner;

  logic v1, v2, v3, rdy1, rdy2, rdy3;
  logic [rrfb_pkg::COLOR_BITS-1:0] dest1, dest2, dest3;
  logic hit1, hit2, hit3, cor1, cor2, cor3;
  logic [MW-1:0] ax1, ay1;
  logic [2*MW-1:0] sqx2, sqy2;
  logic [rrfb_pkg::SQ_PAD_W-1:0] sq3;

  always_comb begin
    x1  = CW'($signed(cfg.left));
    y1  = CW'($signed(cfg.top));
    x2  = x1 + CW'($signed({1'b0, cfg.width}));
    y2  = y1 + CW'($signed({1'b0, cfg.height}));
    pxs = CW'($signed({1'b0, px}));
    pys = CW'($signed({1'b0, py}));
    ri  = CW'($signed({1'b0, cfg.r[rrfb_pkg::RW-1:FB]})) + CW'(1);
    nz  = (cfg.width != '0) && (cfg.height != '0);
    inbox = !((pxs < x1 - CW'(1)) || (pxs >= x2 + CW'(1)) ||
              (pys < y1 - CW'(1)) || (pys >= y2 + CW'(1)));
    left   = pxs < x1 + ri;
    right  = pxs >= x2 - ri;
    top    = pys < y1 + ri;
    bottom = pys >= y2 - ri;
    rr = DW'($signed({1'b0, cfg.r}));
    lx = ((DW'(x1) - DW'(pxs)) <<< FB) + rr - DW'(rrfb_pkg::FX_HALF);
    rx = ((DW'(pxs) - DW'(x2)) <<< FB) + DW'(rrfb_pkg::FX_HALF) + rr;
    ty = ((DW'(y1) - DW'(pys)) <<< FB) + rr - DW'(rrfb_pkg::FX_HALF);
    by = ((DW'(pys) - DW'(y2)) <<< FB) + DW'(rrfb_pkg::FX_HALF) + rr;
    priority if (left && top) begin
      dx = lx; dy = ty;
    end else if (right && top) begin
      dx = rx; dy = ty;
    end else if (left && bottom) begin
      dx = lx; dy = by;
    end else if (right && bottom) begin
      dx = rx; dy = by;
    end else begin
      dx = '0; dy = '0;
    end
    corner = (dx > DW'(0)) && (dy > DW'(0));
  end

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dest1 <= dest;
      hit1  <= nz && inbox;
      cor1  <= corner;
      ax1   <= dx[MW-1:0];
      ay1   <= dy[MW-1:0];
    end
    if (rdy2) begin
      dest2 <= dest1;
      hit2  <= hit1;
      cor2  <= cor1;
      sqx2  <= ax1 * ax1;
      sqy2  <= ay1 * ay1;
    end
    if (rdy3) begin
      dest3 <= dest2;
      hit3  <= hit2;
      cor3  <= cor2;
      sq3   <= rrfb_pkg::SQ_PAD_W'(sqx2) + rrfb_pkg::SQ_PAD_W'(sqy2);
    end
  end

  assign out_valid       = v3;
  assign out_item.dest   = dest3;
  assign out_item.hit    = hit3;
  assign out_item.corner = cor3;
  assign out_item.sq     = sq3;

endmodule

// ===== rtl/rrfb_sqrt.sv =====
// Pipelined digit-by-digit integer square root, a few root bits per stage.
module rrfb_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrfb_pkg::geo_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output rrfb_pkg::root_t out_item
);

  localparam int NS = rrfb_pkg::SQ_STAGES;
  localparam int NR = rrfb_pkg::NROOT;
  localparam int RM = rrfb_pkg::REM_W;
  localparam int AW = rrfb_pkg::SQ_PAD_W;

  logic [NS-1:0] v, rdy, hit, cor;
  logic [NR-1:0] q [NS];
  logic [RM-1:0] rem [NS];
  logic [AW-1:0] rad [NS];
  logic [rrfb_pkg::COLOR_BITS-1:0] dest [NS];

  logic [NR-1:0] q_next [NS];
  logic [RM-1:0] rem_next [NS];
  logic [AW-1:0] rad_next [NS];

  always_comb begin
    logic [NR-1:0] qt;
    logic [RM-1:0] rt, tr;
    logic [AW-1:0] at;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        qt = '0; rt = '0; at = in_item.sq;
      end else begin
        qt = q[s-1]; rt = rem[s-1]; at = rad[s-1];
      end
      for (int k = 0; k < rrfb_pkg::SQ_STEPS; k++) begin
        rt = {rt[RM-3:0], at[AW-1 -: 2]};
        at = {at[AW-3:0], 2'b00};
        tr = RM'({qt, 2'b01});
        if (rt >= tr) begin
          rt = rt - tr;
          qt = {qt[NR-2:0], 1'b1};
        end else begin
          qt = {qt[NR-2:0], 1'b0};
        end
      end
      q_next[s]   = qt;
      rem_next[s] = rt;
      rad_next[s] = at;
    end
  end

  always_comb begin
    rdy[NS-1] = !v[NS-1] || out_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (rdy[s]) v[s] <= v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      q[0]    <= q_next[0];
      rem[0]  <= rem_next[0];
      rad[0]  <= rad_next[0];
      dest[0] <= in_item.dest;
      hit[0]  <= in_item.hit;
      cor[0]  <= in_item.corner;
    end
    for (int s = 1; s < NS; s++) begin
      if (rdy[s]) begin
        q[s]    <= q_next[s];
        rem[s]  <= rem_next[s];
        rad[s]  <= rad_next[s];
        dest[s] <= dest[s-1];
        hit[s]  <= hit[s-1];
        cor[s]  <= cor[s-1];
      end
    end
  end

  assign out_valid       = v[NS-1];
  assign out_item.dest   = dest[NS-1];
  assign out_item.hit    = hit[NS-1];
  assign out_item.corner = cor[NS-1];
  assign out_item.rdist  = q[NS-1];

endmodule

// ===== rtl/rrfb_blend.sv =====
// Coverage, alpha scaling and premultiplied source-over blend, three stages.
module rrfb_blend (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [rrfb_pkg::COLOR_BITS-1:0] color,
  input  logic [rrfb_pkg::RW-1:0]         r,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rrfb_pkg::root_t                 in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rrfb_pkg::COLOR_BITS-1:0] result_pixel,
  output logic                            written
);

  localparam int FB = rrfb_pkg::FRAC_BITS;
  localparam int BW = rrfb_pkg::NROOT + 3;

  logic signed [BW-1:0] dv, rv, cov_full;
  logic beyond, on_rim;
  logic [FB:0] cov;
  logic [FB+8:0] prod;

  logic v1, v2, v3, rdy1, rdy2, rdy3;
  logic [rrfb_pkg::COLOR_BITS-1:0] dest1, dest2, res3;
  logic ok1, w2, opq2, w3;
  logic [7:0] pa1, pa2, inv;
  logic [15:0] ma2, sr2, sg2, sb2, dr2, dg2, db2;

  always_comb begin
    dv = BW'($signed({1'b0, in_item.rdist}));
    rv = BW'($signed({1'b0, r}));
    beyond = in_item.corner && (dv > rv + BW'(rrfb_pkg::FX_HALF));
    on_rim = in_item.corner && (dv > rv - BW'(rrfb_pkg::FX_HALF));
    cov_full = rv + BW'(rrfb_pkg::FX_HALF) - dv;
    cov = on_rim ? cov_full[FB:0] : (FB+1)'(rrfb_pkg::FX_ONE);
    prod = (FB+9)'(color[31:24]) * (FB+9)'(cov);
    inv = 8'hFF - pa1;
  end

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dest1 <= in_item.dest;
      ok1   <= in_item.hit && !beyond;
      pa1   <= prod[FB +: 8];
    end
    if (rdy2) begin
      dest2 <= dest1;
      w2    <= ok1 && (pa1 != 8'd0);
      opq2  <= pa1 == 8'hFF;
      pa2   <= pa1;
      ma2   <= dest1[31:24] * inv;
      dr2   <= dest1[23:16] * inv;
      dg2   <= dest1[15:8] * inv;
      db2   <= dest1[7:0] * inv;
      sr2   <= color[23:16] * pa1;
      sg2   <= color[15:8] * pa1;
      sb2   <= color[7:0] * pa1;
    end
    if (rdy3) begin
      w3 <= w2;
      if (!w2) begin
        res3 <= dest2;
      end else if (opq2) begin
        res3 <= {8'hFF, color[23:0]};
      end else begin
        res3 <= {pa2 + rrfb_pkg::div255(ma2),
                 rrfb_pkg::div255(sr2) + rrfb_pkg::div255(dr2),
                 rrfb_pkg::div255(sg2) + rrfb_pkg::div255(dg2),
                 rrfb_pkg::div255(sb2) + rrfb_pkg::div255(db2)};
      end
    end
  end

  assign out_valid    = v3;
  assign result_pixel = res3;
  assign written      = w3;

endmodule

// ===== rtl/rounded_rect_fill_blend.sv =====
// Top level of the antialiased rounded rectangle fill and source-over blend shader.
// The slave stream carries one pixel per item: x, y and the destination ARGB word.
// The master stream returns one item per pixel: the ARGB word to store in tdata and
// the written flag in tuser, in the order the pixels came in.
// The write port sets rectangle position, size, corner radius and fill color; write
// it only while no pixel is in flight.
// An accepted item passes through three stages of box test, corner offset and squaring,
// seven square-root stages of three root bits each, and three stages of coverage,
// channel products and the divide by 255.
// Throughput is one item per cycle while the receiver keeps m_tready high; every stage is a register with a valid bit.
// When the receiver stalls, each stage holds its item and empty stages keep filling,
// so s_tready drops only once the whole pipeline is full.
// Reset clears all valid bits and the configuration registers to zero (nothing is drawn).
module rounded_rect_fill_blend (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rrfb_pkg::IN_W-1:0]       s_tdata,  // pixel_x, pixel_y, dest_pixel
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rrfb_pkg::COLOR_BITS-1:0] m_tdata,  // result_pixel
  output logic                            m_tuser,  // written
  input  logic                            cfg_we,
  input  logic [rrfb_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [rrfb_pkg::COLOR_BITS-1:0] cfg_data
);

  localparam int CB = rrfb_pkg::COORD_BITS;
  localparam int RB = rrfb_pkg::REG_BITS;
  localparam int EW = rrfb_pkg::RW + rrfb_pkg::SW;

  logic [RB-1:0] rect_left, rect_top, rect_width, rect_height;
  logic [rrfb_pkg::RAD_BITS-1:0] corner_radius;
  logic [rrfb_pkg::COLOR_BITS-1:0] fill_color;

  logic [RB-1:0] side;
  logic [EW-1:0] r_side, r_cfg;
  logic [rrfb_pkg::RW-1:0] r;
  rrfb_pkg::geom_cfg_t gcfg;

  logic g_valid, g_ready, q_valid, q_ready;
  rrfb_pkg::geo_t  g_item;
  rrfb_pkg::root_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left     <= '0;
      rect_top      <= '0;
      rect_width    <= '0;
      rect_height   <= '0;
      corner_radius <= '0;
      fill_color    <= '0;
    end else if (cfg_we) begin
      unique case (rrfb_pkg::cfg_reg_t'(cfg_index))
        rrfb_pkg::REG_LEFT:   rect_left     <= cfg_data[RB-1:0];
        rrfb_pkg::REG_TOP:    rect_top      <= cfg_data[RB-1:0];
        rrfb_pkg::REG_WIDTH:  rect_width    <= cfg_data[RB-1:0];
        rrfb_pkg::REG_HEIGHT: rect_height   <= cfg_data[RB-1:0];
        rrfb_pkg::REG_RADIUS: corner_radius <= cfg_data[rrfb_pkg::RAD_BITS-1:0];
        rrfb_pkg::REG_COLOR:  fill_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    side   = (rect_width < rect_height) ? rect_width : rect_height;
    r_side = EW'(side) << (rrfb_pkg::FRAC_BITS - 1);
    r_cfg  = EW'(corner_radius) << (rrfb_pkg::FRAC_BITS - 4);
    r      = rrfb_pkg::RW'((r_cfg > r_side) ? r_side : r_cfg);
    gcfg.left   = rect_left;
    gcfg.top    = rect_top;
    gcfg.width  = rect_width;
    gcfg.height = rect_height;
    gcfg.r      = r;
  end

  rrfb_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg       (gcfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .px        (s_tdata[CB-1:0]),
    .py        (s_tdata[2*CB-1:CB]),
    .dest      (s_tdata[2*CB +: rrfb_pkg::COLOR_BITS]),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_item  (g_item)
  );

  rrfb_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_item   (g_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  rrfb_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .color        (fill_color),
    .r            (r),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_item      (q_item),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .result_pixel (m_tdata),
    .written      (m_tuser)
  );

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("input stalled with empty output stage");

  a_written_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> fill_color[31:24] != 8'd0)
    else $error("pixel written with zero fill alpha");

  a_zero_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (rect_width == '0 || rect_height == '0) |-> !m_tuser)
    else $error("pixel written for empty rectangle");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("output valid right after reset");

endmodule

// ===== bench/tb.sv =====
// Testbench for the rounded rectangle fill and source-over blend shader.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [31:0] pixel;
    logic        wr;
  } shade_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [rrfb_pkg::IN_W-1:0]       s_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [rrfb_pkg::COLOR_BITS-1:0] m_tdata;
  logic                            m_tuser;
  logic                            cfg_we;
  logic [rrfb_pkg::CFG_IW-1:0]     cfg_index;
  logic [rrfb_pkg::COLOR_BITS-1:0] cfg_data;

  logic [12:0] left_q, top_q, width_q, height_q;
  logic [14:0] radius_q;
  logic [31:0] color_q;

  shade_t shade_q[$];
  int     errors;

  rounded_rect_fill_blend dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic shade_t shade(logic [11:0] px_i, logic [11:0] py_i, logic [31:0] dst);
    shade_t o;
    longint px, py, x1, y1, x2, y2, w, h, r, ri, dx, dy, cov, dval, maxr;
    longint lx, rx, ty, by;
    longint unsigned sq;
    int unsigned a, sr, sg, sb, pa, inv, oa, orr, og, ob;
    bit lf, rt, tp, bt;
    o.pixel = dst;
    o.wr = 0;
    px = px_i;
    py = py_i;
    w = width_q;
    h = height_q;
    if (w == 0 || h == 0) return o;
    x1 = longint'($signed(left_q));
    y1 = longint'($signed(top_q));
    x2 = x1 + w;
    y2 = y1 + h;
    if (px < x1 - 1 || px >= x2 + 1 || py < y1 - 1 || py >= y2 + 1) return o;
    r = longint'(radius_q) * 16;
    maxr = (w < h ? w : h) * 128;
    if (r > maxr) r = maxr;
    ri = (r >> 8) + 1;
    lf = px < x1 + ri;
    rt = px >= x2 - ri;
    tp = py < y1 + ri;
    bt = py >= y2 - ri;
    lx = (x1 - px) * 256 + r - 128;
    rx = (px - x2) * 256 + 128 + r;
    ty = (y1 - py) * 256 + r - 128;
    by = (py - y2) * 256 + 128 + r;
    dx = 0;
    dy = 0;
    if (lf && tp) begin dx = lx; dy = ty; end
    else if (rt && tp) begin dx = rx; dy = ty; end
    else if (lf && bt) begin dx = lx; dy = by; end
    else if (rt && bt) begin dx = rx; dy = by; end
    cov = 256;
    if (dx > 0 && dy > 0) begin
      sq = dx * dx + dy * dy;
      dval = isqrt(sq);
      if (dval > r + 128) return o;
      if (dval > r - 128) cov = r + 128 - dval;
    end
    a = color_q[31:24];
    sr = color_q[23:16];
    sg = color_q[15:8];
    sb = color_q[7:0];
    pa = int'((longint'(a) * cov) >> 8);
    if (pa > 255) pa = 255;
    if (pa == 0) return o;
    if (pa == 255) begin
      o.pixel = {8'hFF, color_q[23:0]};
    end else begin
      inv = 255 - pa;
      oa = pa + (dst[31:24] * inv) / 255;
      orr = (sr * pa) / 255 + (dst[23:16] * inv) / 255;
      og = (sg * pa) / 255 + (dst[15:8] * inv) / 255;
      ob = (sb * pa) / 255 + (dst[7:0] * inv) / 255;
      o.pixel = {oa[7:0], orr[7:0], og[7:0], ob[7:0]};
    end
    o.wr = 1;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  task automatic write_reg(rrfb_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      rrfb_pkg::REG_LEFT:   left_q = val[12:0];
      rrfb_pkg::REG_TOP:    top_q = val[12:0];
      rrfb_pkg::REG_WIDTH:  width_q = val[12:0];
      rrfb_pkg::REG_HEIGHT: height_q = val[12:0];
      rrfb_pkg::REG_RADIUS: radius_q = val[14:0];
      rrfb_pkg::REG_COLOR:  color_q = val;
      default: ;
    endcase
  endtask

  task automatic set_rect(int l, int t, int w, int h, int rad, logic [31:0] col);
    write_reg(rrfb_pkg::REG_LEFT, l);
    write_reg(rrfb_pkg::REG_TOP, t);
    write_reg(rrfb_pkg::REG_WIDTH, w);
    write_reg(rrfb_pkg::REG_HEIGHT, h);
    write_reg(rrfb_pkg::REG_RADIUS, rad);
    write_reg(rrfb_pkg::REG_COLOR, col);
  endtask

  task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] dst, bit gaps = 1);
    int g;
    g = gaps ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (g != 0) begin
      s_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {dst, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shade_q.push_back(shade(x, y, dst));
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 0;
    while (shade_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    set_rect(100, 50, 40, 30, 10 * 16, 32'h80FF4020);
    send_pixel(99, 49, 32'h11223344);
    send_pixel(100, 50, 32'hFFFFFFFF);
    send_pixel(110, 60, 32'h00000000);
    send_pixel(140, 80, 32'h12345678);
    send_pixel(141, 80, 32'h12345678);
    send_pixel(98, 60, 32'hDEADBEEF);
    send_pixel(139, 79, 32'hA5A5A5A5);
    send_pixel(103, 53, 32'h5A5A5A5A);
    drain();
    set_rect(0, 0, 4096, 4096, 32767, 32'hFF00FF00);
    send_pixel(0, 0, 32'h0);
    send_pixel(4095, 4095, 32'hFFFFFFFF);
    send_pixel(2048, 2048, 32'h01020304);
    send_pixel(4095, 0, 32'h0);
    drain();
    set_rect(-4096, -4096, 4100, 3, 40, 32'h01FFFFFF);
    send_pixel(2, 0, 32'hFFFFFFFF);
    send_pixel(0, 0, 32'h00000000);
    send_pixel(4, 0, 32'h80808080);
    drain();
    set_rect(4095, 4095, 0, 5, 0, 32'hFFFFFFFF);
    send_pixel(4095, 4095, 32'hCAFEF00D);
    drain();
    set_rect(10, 10, 2, 9, 100, 32'h00FFFFFF);
    send_pixel(10, 10, 32'h77777777);
    send_pixel(11, 12, 32'h77777777);
    drain();
  endtask

  task automatic test_random();
    int ph, n, l, t, w, h, sx, sy;
    for (ph = 0; ph < 23; ph++) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 40);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 40);
      l = $urandom_range(0, 4) == 0 ? int'($urandom_range(0, 8191)) - 4096
                                    : $urandom_range(0, 4050);
      t = $urandom_range(0, 4) == 0 ? int'($urandom_range(0, 8191)) - 4096
                                    : $urandom_range(0, 4050);
      set_rect(l, t, w, h, $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
               : $urandom_range(0, 400), $urandom());
      if ($urandom_range(0, 3) == 0)
        write_reg(rrfb_pkg::REG_COLOR, {8'hFF, 24'($urandom())});
      for (n = 0; n < 50; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          sx = $urandom_range(0, 4095);
          sy = $urandom_range(0, 4095);
        end else begin
          sx = (l + int'($urandom_range(0, (w < 60 ? w : 60) + 2)) - 1) & 12'hFFF;
          sy = (t + int'($urandom_range(0, (h < 60 ? h : 60) + 2)) - 1) & 12'hFFF;
        end
        send_pixel(12'(sx), 12'(sy), $urandom(), ph % 3 != 0);
      end
      drain();
    end
  endtask

  always @(posedge clk) begin
    shade_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (shade_q.size() == 0) begin
        report("unexpected item", m_tdata, '0);
      end else begin
        e = shade_q.pop_front();
        if (m_tdata !== e.pixel) report("result_pixel", m_tdata, e.pixel);
        if (m_tuser !== e.wr) report("written", {31'd0, m_tuser}, {31'd0, e.wr});
      end
    end
  end

  initial begin
    int w;
    m_tready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = $urandom_range(0, 10);
      if (w != 0) begin
        m_tready <= 0;
        repeat (w) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    errors = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_we = 0;
    cfg_index = rrfb_pkg::REG_LEFT;
    cfg_data = '0;
    left_q = 0; top_q = 0; width_q = 0; height_q = 0; radius_q = 0; color_q = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send_pixel(5, 5, 32'h12345678);
    drain();
    test_directed();
    test_random();
    drain();
    if (errors == 0 && shade_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/rrfb_pkg.sv
rtl/rrfb_geom.sv
rtl/rrfb_sqrt.sv
rtl/rrfb_blend.sv
rtl/rounded_rect_fill_blend.sv
bench/tb.sv
